// ===== rtl/asbms_pkg.sv =====
// shared types and constants for the ascii block mean / deviation unit
// no dependencies
`default_nettype none
package asbms_pkg;

  localparam int MaxEnsemble = 1024;
  localparam int MaxDigits   = 4;
  localparam int EnsW        = 11;   // register and count width, holds MaxEnsemble
  localparam int LineW       = 14;   // up to four decimal digits
  localparam int CcW         = 3;
  localparam int SumW        = 24;
  localparam int SqW         = 37;
  localparam int OutW        = 22;
  localparam int ProdW       = 48;   // n * square_sum
  localparam int NumW        = 64;   // divider numerator and quotient
  localparam int DvsW        = 20;   // n * (n - 1)
  localparam int RadW        = 44;   // sqrt radicand
  localparam int SqrtRemW    = 25;

  localparam logic [7:0] NewlineChar = 8'd10;
  localparam logic [7:0] DigitZero   = 8'd48;
  localparam logic [7:0] DigitNine   = 8'd57;
  localparam logic [EnsW-1:0] EnsReset = EnsW'(6);
  localparam logic [EnsW-1:0] EnsMin   = EnsW'(2);
  localparam logic [EnsW-1:0] EnsMax   = EnsW'(MaxEnsemble);

  // one finished ensemble handed from the parser to the math unit
  typedef struct packed {
    logic [EnsW-1:0] n;
    logic [SumW-1:0] value_sum;
    logic [SqW-1:0]  square_sum;
    logic            overflow;
  } ens_rec_t;

endpackage
`default_nettype wire

// ===== rtl/asbms_front.sv =====
// line parser and accumulator: bytes in, ensemble records out
// depends on asbms_pkg
`default_nettype none
module asbms_front (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     take_i,
  input  wire [7:0]               rx_byte_i,
  input  wire [asbms_pkg::EnsW-1:0] ens_size_i,
  output logic                    push_o,
  output asbms_pkg::ens_rec_t     rec_o
);
  import asbms_pkg::*;

  logic [LineW-1:0] line_q, line_d;
  logic [CcW-1:0]   cc_q, cc_d;
  logic             ended_q, ended_d;
  logic             first_q, first_d;
  logic [EnsW-1:0]  idx_q, idx_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [SqW-1:0]   sq_q, sq_d;
  logic             ovf_q, ovf_d;
  logic [EnsW-1:0]  n_eff, idx_inc;
  logic [SumW-1:0]  sum_inc;
  logic [SqW-1:0]   sq_inc;
  logic [2*LineW-1:0] sqr;
  logic [LineW-1:0] line_x10;
  logic             is_digit;

  always_comb begin
    if (ens_size_i < EnsMin) n_eff = EnsMin;
    else if (ens_size_i > EnsMax) n_eff = EnsMax;
    else n_eff = ens_size_i;
  end

  assign is_digit = (rx_byte_i >= DigitZero) && (rx_byte_i <= DigitNine);
  assign line_x10 = (line_q << 3) + (line_q << 1);
  assign sqr      = line_q * line_q;
  assign sum_inc  = sum_q + SumW'(line_q);
  assign sq_inc   = sq_q + SqW'(sqr);
  assign idx_inc  = idx_q + EnsW'(1);

  always_comb begin
    line_d  = line_q;
    cc_d    = cc_q;
    ended_d = ended_q;
    first_d = first_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    sq_d    = sq_q;
    ovf_d   = ovf_q;
    push_o  = 1'b0;
    rec_o   = '{n: idx_inc, value_sum: sum_inc, square_sum: sq_inc, overflow: ovf_q};
    if (take_i) begin
      if (rx_byte_i != NewlineChar) begin
        if (cc_q >= CcW'(MaxDigits)) begin
          if (!first_q) ovf_d = 1'b1;
        end else begin
          cc_d = cc_q + CcW'(1);
          if (!ended_q) begin
            if (is_digit) line_d = line_x10 + LineW'(rx_byte_i - DigitZero);
            else ended_d = 1'b1;
          end
        end
      end else begin
        line_d  = '0;
        cc_d    = '0;
        ended_d = 1'b0;
        if (first_q) begin
          first_d = 1'b0;
        end else if (idx_inc >= n_eff) begin
          push_o = 1'b1;
          idx_d  = '0;
          sum_d  = '0;
          sq_d   = '0;
          ovf_d  = 1'b0;
        end else begin
          idx_d = idx_inc;
          sum_d = sum_inc;
          sq_d  = sq_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= '0;
      cc_q    <= '0;
      ended_q <= 1'b0;
      first_q <= 1'b1;
      idx_q   <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      ovf_q   <= 1'b0;
    end else begin
      line_q  <= line_d;
      cc_q    <= cc_d;
      ended_q <= ended_d;
      first_q <= first_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      sq_q    <= sq_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/asbms_queue.sv =====
// two-entry record queue between parser and math unit
// depends on asbms_pkg
`default_nettype none
module asbms_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  asbms_pkg::ens_rec_t rec_i,
  input  wire                 pop_i,
  output asbms_pkg::ens_rec_t rec_o,
  output logic                full_o,
  output logic                empty_o
);
  import asbms_pkg::*;

  ens_rec_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rec_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/asbms_back.sv =====
// sequential mean and deviation math: shift-add multiply, shared restoring
// divider, digit-by-digit square root; owns the result register. depends on asbms_pkg
`default_nettype none
module asbms_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 empty_i,
  input  asbms_pkg::ens_rec_t rec_i,
  output logic                pop_o,
  output logic                res_valid_o,
  input  wire                 res_stall_i,
  output logic [asbms_pkg::OutW-1:0] mean_q8_o,
  output logic [asbms_pkg::OutW-1:0] std_q8_o,
  output logic                line_overflow_o
);
  import asbms_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StDivM = 3'd2;
  localparam logic [2:0] StDivS = 3'd3;
  localparam logic [2:0] StSqrt = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]            st_q;
  logic [5:0]            cnt_q;
  logic [EnsW-1:0]       n_q, mpl_q;
  logic [ProdW-1:0]      mcand_q, acc_q, b_q, d_q;
  logic [DvsW-1:0]       m_q, dvs_q, drem_q;
  logic [NumW-1:0]       num_q;
  logic [OutW-1:0]       mean_q, root_q;
  logic [RadW-1:0]       rad_q;
  logic [SqrtRemW-1:0]   srem_q;
  logic                  ovf_q;
  logic                  out_free;

  logic [DvsW:0]         dtrial;
  logic                  dge;
  logic [SqrtRemW-1:0]   stry, sbit;
  logic                  sge;
  logic [2*EnsW-1:0]     mm;

  assign out_free = !res_valid_o || !res_stall_i;
  assign pop_o    = (st_q == StIdle) && !empty_i;

  assign dtrial = {drem_q, num_q[NumW-1]};
  assign dge    = dtrial >= {1'b0, dvs_q};
  assign stry   = {srem_q[SqrtRemW-3:0], rad_q[RadW-1 -: 2]};
  assign sbit   = SqrtRemW'({root_q, 2'b01});
  assign sge    = stry >= sbit;
  assign mm     = n_q * (n_q - EnsW'(1));

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        n_q     <= rec_i.n;
        mpl_q   <= rec_i.n;
        mcand_q <= ProdW'(rec_i.square_sum);
        acc_q   <= '0;
        b_q     <= ProdW'(rec_i.value_sum) * ProdW'(rec_i.value_sum);
        ovf_q   <= rec_i.overflow;
        num_q   <= NumW'({rec_i.value_sum, 8'b0} + 32'(rec_i.n >> 1));
        dvs_q   <= DvsW'(rec_i.n);
        drem_q  <= '0;
        m_q     <= '0;
      end
      StMul: begin
        m_q     <= DvsW'(mm);
        if (mpl_q[0]) acc_q <= acc_q + mcand_q;
        mcand_q <= mcand_q << 1;
        mpl_q   <= mpl_q >> 1;
        d_q     <= (acc_q > b_q) ? acc_q - b_q : '0;
      end
      StDivM, StDivS: begin
        if (cnt_q == 6'd63 && st_q == StDivM) begin
          // mean done, load the variance division
          mean_q <= OutW'({num_q[NumW-2:0], dge});
          num_q  <= {d_q, 16'b0};
          dvs_q  <= m_q;
          drem_q <= '0;
        end else begin
          drem_q <= dge ? DvsW'(dtrial - {1'b0, dvs_q}) : DvsW'(dtrial);
          num_q  <= {num_q[NumW-2:0], dge};
        end
        if (cnt_q == 6'd63 && st_q == StDivS) begin
          rad_q  <= {num_q[RadW-2:0], dge};
          srem_q <= '0;
          root_q <= '0;
        end
      end
      StSqrt: begin
        srem_q <= sge ? stry - sbit : stry;
        root_q <= {root_q[OutW-2:0], sge};
        rad_q  <= rad_q << 2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      cnt_q       <= '0;
      res_valid_o <= 1'b0;
    end else begin
      if (st_q == StOut && out_free) res_valid_o <= 1'b1;
      else if (!res_stall_i) res_valid_o <= 1'b0;
      case (st_q)
        StIdle: if (!empty_i) begin
          st_q  <= StMul;
          cnt_q <= '0;
        end
        StMul: begin
          // the final step only settles the difference register
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(EnsW)) begin
            st_q  <= StDivM;
            cnt_q <= '0;
          end
        end
        StDivM: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) st_q <= StDivS;
        end
        StDivS: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) st_q <= StSqrt;
        end
        StSqrt: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(OutW - 1)) st_q <= StOut;
        end
        StOut: if (out_free) begin
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StOut && out_free) begin
      mean_q8_o       <= mean_q;
      std_q8_o        <= (SqrtRemW'(root_q) < srem_q) ? root_q + OutW'(1) : root_q;
      line_overflow_o <= ovf_q;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ascii_sample_block_mean_std.sv =====
// top level: parser front, record queue, math back
// depends on asbms_pkg, asbms_front, asbms_queue, asbms_back
//
// usage
//   rx channel: one ascii byte per beat (rx_valid_i / rx_stall_o). lines end in
//   newline and carry an unsigned decimal reading; the first line after reset
//   is dropped.
//   res channel: one beat per ensemble (res_valid_o / res_stall_i) with mean,
//   sample deviation (both q8) and the line overflow flag.
//   ensemble_size_we_i writes ensemble_size_i; reset value 6, clamped to 2..1024.
//   order: after the closing newline is taken, its record enters the queue,
//   then the math unit starts, runs a shift-add multiply, two 64-step divisions
//   and a 22-step root, and loads the result register; res_valid_o then rises.
//   throughput: up to two finished ensembles queue up; rx stalls only while
//   both queue slots are full. a stalled result holds, and the math unit
//   waits at its final step until the result register frees.
//   reset clears the parser sums, the counters, the queue and the result valid.
`default_nettype none
module ascii_sample_block_mean_std (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        rx_valid_i,
  output logic                       rx_stall_o,
  input  wire [7:0]                  rx_byte_i,
  input  wire                        ensemble_size_we_i,
  input  wire [asbms_pkg::EnsW-1:0]  ensemble_size_i,
  output logic                       res_valid_o,
  input  wire                        res_stall_i,
  output logic [asbms_pkg::OutW-1:0] mean_q8_o,
  output logic [asbms_pkg::OutW-1:0] std_q8_o,
  output logic                       line_overflow_o
);
  import asbms_pkg::*;

  logic [EnsW-1:0] ens_q;
  logic            push, pop, full, empty;
  ens_rec_t        rec_in, rec_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ens_q <= EnsReset;
    else if (ensemble_size_we_i) ens_q <= ensemble_size_i;
  end

  assign rx_stall_o = full;

  asbms_front u_front (
    .clk_i, .rst_ni,
    .take_i     (rx_valid_i && !full),
    .rx_byte_i,
    .ens_size_i (ens_q),
    .push_o     (push),
    .rec_o      (rec_in)
  );

  asbms_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .rec_i   (rec_in),
    .pop_i   (pop),
    .rec_o   (rec_out),
    .full_o  (full),
    .empty_o (empty)
  );

  asbms_back u_back (
    .clk_i, .rst_ni,
    .empty_i (empty),
    .rec_i   (rec_out),
    .pop_o   (pop),
    .res_valid_o,
    .res_stall_i,
    .mean_q8_o,
    .std_q8_o,
    .line_overflow_o
  );

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("record queue overrun");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("record queue underrun");
  a_rec_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> rec_in.n >= EnsMin) else $error("ensemble record too short");

endmodule
`default_nettype wire
